>>> rtl/core/bdlp_pkg.sv
// ----------------------------------------------------------------------------
// bdlp_pkg
// shared types and constants of the button debounce / long-press block
// ----------------------------------------------------------------------------
package bdlp_pkg;

    localparam int unsigned IDX_W    = 3;
    localparam int unsigned TIME_W   = 48;
    localparam int unsigned DEB_W    = 20;
    localparam int unsigned WARM_W   = 24;
    localparam int unsigned LPMS_W   = 16;
    localparam int unsigned MASK_W   = 8;
    localparam int unsigned THR_W    = 26;
    localparam int unsigned US_PER_MS = 1000;

    localparam int unsigned PADDR_W  = 5;
    localparam int unsigned PDATA_W  = 32;

    // register index, taken from paddr word offset
    typedef enum logic [2:0] {
        REG_DEBOUNCE   = 3'd0,
        REG_WARMUP     = 3'd1,
        REG_LONG_MS    = 3'd2,
        REG_PULL_UP    = 3'd3,
        REG_LONG_MASK  = 3'd4
    } reg_idx_t;

    localparam logic [DEB_W-1:0]  DEBOUNCE_RST  = DEB_W'(20000);
    localparam logic [WARM_W-1:0] WARMUP_RST    = WARM_W'(500000);
    localparam logic [LPMS_W-1:0] LONG_MS_RST   = LPMS_W'(1000);
    localparam logic [MASK_W-1:0] PULL_UP_RST   = MASK_W'(255);
    localparam logic [MASK_W-1:0] LONG_MASK_RST = MASK_W'(0);

    // per-button state word kept in the state ram
    typedef struct packed {
        logic              last_raw;
        logic [TIME_W-1:0] raw_change_time;
        logic              accepted;
        logic [TIME_W-1:0] press_start;
        logic              long_fired;
    } btn_entry_t;

endpackage

>>> rtl/core/bdlp_sample_if.sv
// ----------------------------------------------------------------------------
// bdlp_sample_if
// valid/ready channel carrying one raw button sample
// ----------------------------------------------------------------------------
interface bdlp_sample_if;

    logic                             valid;
    logic                             ready;
    logic [bdlp_pkg::IDX_W-1:0]       button_index;
    logic                             raw_level;
    logic [bdlp_pkg::TIME_W-1:0]      now_us;

    modport source (output valid, output button_index, output raw_level, output now_us,
                    input ready);
    modport sink   (input valid, input button_index, input raw_level, input now_us,
                    output ready);

endinterface

>>> rtl/core/bdlp_report_if.sv
// ----------------------------------------------------------------------------
// bdlp_report_if
// valid/ready channel carrying one event report
// ----------------------------------------------------------------------------
interface bdlp_report_if;

    logic                             valid;
    logic                             ready;
    logic [bdlp_pkg::IDX_W-1:0]       button_id;
    logic                             press_event;
    logic                             long_press_event;
    logic                             release_event;
    logic                             debounced_state;

    modport source (output valid, output button_id, output press_event,
                    output long_press_event, output release_event, output debounced_state,
                    input ready);
    modport sink   (input valid, input button_id, input press_event,
                    input long_press_event, input release_event, input debounced_state,
                    output ready);

endinterface

>>> rtl/core/bdlp_ram.sv
// ----------------------------------------------------------------------------
// bdlp_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module bdlp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/button_debounce_long_press.sv
// ----------------------------------------------------------------------------
// button_debounce_long_press
// per-button debounce with press, long-press and release reporting
// ----------------------------------------------------------------------------
// Takes one raw sample per item and returns exactly one report item for it.
// Throughput is one item per clock while the report side takes items; each
// sample passes the read stage, where the state ram is read and the update
// is made, and then sits in the output register, where its report item is
// offered. The per-button state lives in a small ram read at accept time and
// written back when the item moves to the output register; a sample of the
// same button right behind it gets the fresh word from a bypass register.
// A ram entry reads as all zero until its button is first written. Samples
// whose index is not below NUM_BUTTONS pass through with all events and the
// debounced state zero and change nothing. The user must write registers
// through the APB port only while no item is in flight; the block does not enforce it.
module button_debounce_long_press #(
    parameter int unsigned NUM_BUTTONS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,

    bdlp_sample_if.sink                       sample,
    bdlp_report_if.source                     report,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bdlp_pkg::PADDR_W-1:0]      paddr,
    input  logic [bdlp_pkg::PDATA_W-1:0]      pwdata,
    output logic [bdlp_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    localparam int unsigned AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int unsigned EW = $bits(bdlp_pkg::btn_entry_t);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [bdlp_pkg::DEB_W-1:0]  debounce_reg,  debounce_next;
    logic [bdlp_pkg::WARM_W-1:0] warmup_reg,    warmup_next;
    logic [bdlp_pkg::LPMS_W-1:0] long_ms_reg,   long_ms_next;
    logic [bdlp_pkg::MASK_W-1:0] pull_up_reg,   pull_up_next;
    logic [bdlp_pkg::MASK_W-1:0] long_mask_reg, long_mask_next;
    logic [bdlp_pkg::THR_W-1:0]  long_thr_reg,  long_thr_next;
    logic                        cfg_wr;
    bdlp_pkg::reg_idx_t          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = bdlp_pkg::reg_idx_t'(paddr[4:2]);

    always_comb
    begin
        debounce_next  = debounce_reg;
        warmup_next    = warmup_reg;
        long_ms_next   = long_ms_reg;
        pull_up_next   = pull_up_reg;
        long_mask_next = long_mask_reg;
        if (cfg_wr)
        begin
            case (cfg_idx)
                bdlp_pkg::REG_DEBOUNCE:  debounce_next  = pwdata[bdlp_pkg::DEB_W-1:0];
                bdlp_pkg::REG_WARMUP:    warmup_next    = pwdata[bdlp_pkg::WARM_W-1:0];
                bdlp_pkg::REG_LONG_MS:   long_ms_next   = pwdata[bdlp_pkg::LPMS_W-1:0];
                bdlp_pkg::REG_PULL_UP:   pull_up_next   = pwdata[bdlp_pkg::MASK_W-1:0];
                bdlp_pkg::REG_LONG_MASK: long_mask_next = pwdata[bdlp_pkg::MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // long-press threshold in microseconds, registered from the long_ms register after a write
    assign long_thr_next = bdlp_pkg::THR_W'(long_ms_reg * bdlp_pkg::US_PER_MS);

    always_comb
    begin
        case (cfg_idx)
            bdlp_pkg::REG_DEBOUNCE:  prdata = bdlp_pkg::PDATA_W'(debounce_reg);
            bdlp_pkg::REG_WARMUP:    prdata = bdlp_pkg::PDATA_W'(warmup_reg);
            bdlp_pkg::REG_LONG_MS:   prdata = bdlp_pkg::PDATA_W'(long_ms_reg);
            bdlp_pkg::REG_PULL_UP:   prdata = bdlp_pkg::PDATA_W'(pull_up_reg);
            bdlp_pkg::REG_LONG_MASK: prdata = bdlp_pkg::PDATA_W'(long_mask_reg);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg  <= bdlp_pkg::DEBOUNCE_RST;
            warmup_reg    <= bdlp_pkg::WARMUP_RST;
            long_ms_reg   <= bdlp_pkg::LONG_MS_RST;
            pull_up_reg   <= bdlp_pkg::PULL_UP_RST;
            long_mask_reg <= bdlp_pkg::LONG_MASK_RST;
            long_thr_reg  <= bdlp_pkg::THR_W'(1000 * 1000);
        end
        else
        begin
            debounce_reg  <= debounce_next;
            warmup_reg    <= warmup_next;
            long_ms_reg   <= long_ms_next;
            pull_up_reg   <= pull_up_next;
            long_mask_reg <= long_mask_next;
            long_thr_reg  <= long_thr_next;
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: read stage, then output register
    // ------------------------------------------------------------------
    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    logic out_free, s1_adv, accept;

    assign out_free      = !out_valid_reg || report.ready;
    assign s1_adv        = s1_valid_reg && out_free;
    assign sample.ready  = !s1_valid_reg || out_free;
    assign accept        = sample.valid && sample.ready;

    assign s1_valid_next  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_adv ? 1'b1 : (report.ready ? 1'b0 : out_valid_reg);

    // ------------------------------------------------------------------
    // read stage payload
    // ------------------------------------------------------------------
    logic [bdlp_pkg::IDX_W-1:0]  s1_idx_reg,   s1_idx_next;
    logic                        s1_level_reg, s1_level_next;
    logic [bdlp_pkg::TIME_W-1:0] s1_now_reg,   s1_now_next;
    logic                        s1_inr_reg,   s1_inr_next;
    logic                        in_range;
    logic [AW-1:0]               rd_addr;
    logic [AW-1:0]               s1_addr;

    assign in_range = 32'(sample.button_index) < NUM_BUTTONS;
    assign rd_addr  = AW'(sample.button_index);
    assign s1_addr  = AW'(s1_idx_reg);

    assign s1_idx_next   = accept ? sample.button_index : s1_idx_reg;
    assign s1_level_next = accept ? sample.raw_level    : s1_level_reg;
    assign s1_now_next   = accept ? sample.now_us       : s1_now_reg;
    assign s1_inr_next   = accept ? in_range            : s1_inr_reg;

    always_ff @(posedge clk)
    begin
        s1_idx_reg   <= s1_idx_next;
        s1_level_reg <= s1_level_next;
        s1_now_reg   <= s1_now_next;
        s1_inr_reg   <= s1_inr_next;
    end

    // ------------------------------------------------------------------
    // state ram, entry valid bits and same-button bypass
    // ------------------------------------------------------------------
    logic                    wr_en;
    logic [EW-1:0]           ram_rdata;
    bdlp_pkg::btn_entry_t    wr_entry;
    logic [NUM_BUTTONS-1:0]  ent_valid_reg, ent_valid_next;
    logic                    fwd_hit_reg,   fwd_hit_next;
    bdlp_pkg::btn_entry_t    fwd_data_reg,  fwd_data_next;
    bdlp_pkg::btn_entry_t    cur;

    assign wr_en = s1_adv && s1_inr_reg;

    bdlp_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_BUTTONS)
    ) u_state_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_addr),
        .wdata (wr_entry),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        ent_valid_next = ent_valid_reg;
        if (wr_en)
        begin
            ent_valid_next[s1_addr] = 1'b1;
        end
    end

    // the item behind reads the ram in the same cycle its predecessor writes
    assign fwd_hit_next  = accept ? (wr_en && (s1_addr == rd_addr)) : fwd_hit_reg;
    assign fwd_data_next = wr_en ? wr_entry : fwd_data_reg;

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= fwd_data_next;
    end

    always_comb
    begin
        if (fwd_hit_reg)
        begin
            cur = fwd_data_reg;
        end
        else if (ent_valid_reg[s1_addr])
        begin
            cur = bdlp_pkg::btn_entry_t'(ram_rdata);
        end
        else
        begin
            cur = '0;
        end
    end

    // ------------------------------------------------------------------
    // shared warm-up start time
    // ------------------------------------------------------------------
    logic                        started_reg,    started_next;
    logic [bdlp_pkg::TIME_W-1:0] start_time_reg, start_time_next;
    logic [bdlp_pkg::TIME_W-1:0] start_eff;

    assign start_eff       = started_reg ? start_time_reg : s1_now_reg;
    assign started_next    = wr_en ? 1'b1 : started_reg;
    assign start_time_next = wr_en ? start_eff : start_time_reg;

    always_ff @(posedge clk)
    begin
        start_time_reg <= start_time_next;
    end

    // ------------------------------------------------------------------
    // debounce and event logic
    // ------------------------------------------------------------------
    logic                        active, changed, prev, pressed, has_long, in_warmup;
    logic [bdlp_pkg::TIME_W-1:0] rct_eff, since_chg, since_start, since_press;
    logic                        ev_press, ev_long, ev_rel, lf_eff;

    always_comb
    begin
        active      = pull_up_reg[s1_idx_reg] ? !s1_level_reg : s1_level_reg;
        changed     = active != cur.last_raw;
        rct_eff     = changed ? s1_now_reg : cur.raw_change_time;
        since_chg   = s1_now_reg - rct_eff;
        since_start = s1_now_reg - start_eff;
        since_press = s1_now_reg - cur.press_start;
        prev        = cur.accepted;
        pressed     = (since_chg >= bdlp_pkg::TIME_W'(debounce_reg)) ? active : prev;
        in_warmup   = since_start < bdlp_pkg::TIME_W'(warmup_reg);
        has_long    = long_mask_reg[s1_idx_reg] && (long_ms_reg != '0);

        ev_press = 1'b0;
        ev_long  = 1'b0;
        ev_rel   = 1'b0;

        wr_entry                 = cur;
        wr_entry.last_raw        = active;
        wr_entry.raw_change_time = rct_eff;
        wr_entry.accepted        = pressed;

        if (!in_warmup)
        begin
            lf_eff = cur.long_fired;
            // rising edge of accepted state: press starts now
            if (pressed && !prev)
            begin
                wr_entry.press_start = s1_now_reg;
                lf_eff               = 1'b0;
                ev_press             = !has_long;
            end
            // a press starting this sample has zero hold time, below any threshold
            else if (pressed && !lf_eff && has_long &&
                     since_press >= bdlp_pkg::TIME_W'(long_thr_reg))
            begin
                lf_eff  = 1'b1;
                ev_long = 1'b1;
            end
            // falling edge: tap or release unless long press already reported
            if (!pressed && prev)
            begin
                ev_press             = has_long && !lf_eff;
                ev_rel               = !lf_eff;
                wr_entry.press_start = '0;
                lf_eff               = 1'b0;
            end
            wr_entry.long_fired = lf_eff;
        end
        else
        begin
            lf_eff = cur.long_fired;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic [bdlp_pkg::IDX_W-1:0] o_id_reg,    o_id_next;
    logic                       o_press_reg, o_press_next;
    logic                       o_long_reg,  o_long_next;
    logic                       o_rel_reg,   o_rel_next;
    logic                       o_state_reg, o_state_next;

    assign o_id_next    = s1_adv ? s1_idx_reg                      : o_id_reg;
    assign o_press_next = s1_adv ? (s1_inr_reg && ev_press)        : o_press_reg;
    assign o_long_next  = s1_adv ? (s1_inr_reg && ev_long)         : o_long_reg;
    assign o_rel_next   = s1_adv ? (s1_inr_reg && ev_rel)          : o_rel_reg;
    assign o_state_next = s1_adv ? (s1_inr_reg && pressed)         : o_state_reg;

    always_ff @(posedge clk)
    begin
        o_id_reg    <= o_id_next;
        o_press_reg <= o_press_next;
        o_long_reg  <= o_long_next;
        o_rel_reg   <= o_rel_next;
        o_state_reg <= o_state_next;
    end

    assign report.valid            = out_valid_reg;
    assign report.button_id        = o_id_reg;
    assign report.press_event      = o_press_reg;
    assign report.long_press_event = o_long_reg;
    assign report.release_event    = o_rel_reg;
    assign report.debounced_state  = o_state_reg;

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ent_valid_reg <= '0;
            fwd_hit_reg   <= 1'b0;
            started_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            ent_valid_reg <= ent_valid_next;
            fwd_hit_reg   <= fwd_hit_next;
            started_reg   <= started_next;
        end
    end

endmodule

>>> test/bdlp_report_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlp_report_checker
// watches the sample, report and register ports of the debouncer, keeps its
// own copy of the per-button state, and checks every report item in order
// ----------------------------------------------------------------------------
module bdlp_report_checker
    import bdlp_pkg::*;
#(
    parameter int unsigned NUM_BUTTONS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    bdlp_sample_if             smp,
    bdlp_report_if             rpt,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output int                 failures,
    output int                 pending,
    output int                 samples,
    output int                 presses,
    output int                 long_presses,
    output int                 releases
);

    typedef struct packed {
        logic [IDX_W-1:0] button_id;
        logic             press;
        logic             long_press;
        logic             released;
        logic             pressed;
    } report_t;

    // register copy
    logic [DEB_W-1:0]  debounce;
    logic [WARM_W-1:0] warmup;
    logic [LPMS_W-1:0] long_ms;
    logic [MASK_W-1:0] pull_up;
    logic [MASK_W-1:0] long_mask;

    // per-button state copy
    logic              last_active [NUM_BUTTONS];
    logic [TIME_W-1:0] change_at   [NUM_BUTTONS];
    logic              held        [NUM_BUTTONS];
    logic [TIME_W-1:0] held_since  [NUM_BUTTONS];
    logic              long_done   [NUM_BUTTONS];
    logic [TIME_W-1:0] first_seen;
    logic              seen_any;

    report_t expected_reports[$];

    function automatic report_t predict_report(input logic [IDX_W-1:0] b, input logic lvl,
                                               input logic [TIME_W-1:0] now);
        report_t           r;
        logic              act;
        logic              prev;
        logic              now_held;
        logic              long_on;
        logic [TIME_W-1:0] since_change;
        logic [TIME_W-1:0] since_start;
        logic [TIME_W-1:0] since_press;
        logic [TIME_W-1:0] thr;
        r = '0;
        r.button_id = b;
        if (int'(b) >= NUM_BUTTONS)
        begin
            return r;
        end
        if (!seen_any)
        begin
            seen_any   = 1'b1;
            first_seen = now;
        end
        act = pull_up[b] ? !lvl : lvl;
        if (act != last_active[b])
        begin
            last_active[b] = act;
            change_at[b]   = now;
        end
        prev         = held[b];
        since_change = now - change_at[b];
        now_held     = (since_change >= TIME_W'(debounce)) ? act : prev;
        since_start  = now - first_seen;
        if (since_start < TIME_W'(warmup))
        begin
            held[b]   = now_held;
            r.pressed = now_held;
            return r;
        end
        long_on = long_mask[b] && (long_ms != '0);
        thr     = TIME_W'(long_ms) * TIME_W'(US_PER_MS);
        if (now_held && !prev)
        begin
            held_since[b] = now;
            long_done[b]  = 1'b0;
            if (!long_on)
            begin
                r.press = 1'b1;
            end
        end
        since_press = now - held_since[b];
        if (now_held && !long_done[b] && long_on && since_press >= thr)
        begin
            long_done[b] = 1'b1;
            r.long_press = 1'b1;
        end
        if (!now_held && prev)
        begin
            if (!long_done[b])
            begin
                if (long_on)
                begin
                    r.press = 1'b1;
                end
                r.released = 1'b1;
            end
            held_since[b] = '0;
            long_done[b]  = 1'b0;
        end
        held[b]   = now_held;
        r.pressed = now_held;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        report_t got;
        report_t want;
        if (!rst_n)
        begin
            debounce  = DEBOUNCE_RST;
            warmup    = WARMUP_RST;
            long_ms   = LONG_MS_RST;
            pull_up   = PULL_UP_RST;
            long_mask = LONG_MASK_RST;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                last_active[i] = 1'b0;
                change_at[i]   = '0;
                held[i]        = 1'b0;
                held_since[i]  = '0;
                long_done[i]   = 1'b0;
            end
            first_seen = '0;
            seen_any   = 1'b0;
            expected_reports.delete();
            failures     = 0;
            pending      = 0;
            samples      = 0;
            presses      = 0;
            long_presses = 0;
            releases     = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[PADDR_W-1:2]))
                    REG_DEBOUNCE:  debounce  = pwdata[DEB_W-1:0];
                    REG_WARMUP:    warmup    = pwdata[WARM_W-1:0];
                    REG_LONG_MS:   long_ms   = pwdata[LPMS_W-1:0];
                    REG_PULL_UP:   pull_up   = pwdata[MASK_W-1:0];
                    REG_LONG_MASK: long_mask = pwdata[MASK_W-1:0];
                    default:       ;
                endcase
            end
            if (smp.valid && smp.ready)
            begin
                expected_reports.push_back(predict_report(smp.button_index, smp.raw_level,
                                                          smp.now_us));
                samples++;
            end
            if (rpt.valid && rpt.ready)
            begin
                got.button_id  = rpt.button_id;
                got.press      = rpt.press_event;
                got.long_press = rpt.long_press_event;
                got.released   = rpt.release_event;
                got.pressed    = rpt.debounced_state;
                if (expected_reports.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("%0t: report item with none expected: id=%0d p=%0b l=%0b r=%0b s=%0b",
                                 $realtime, got.button_id, got.press, got.long_press,
                                 got.released, got.pressed);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (got.button_id !== want.button_id || got.press !== want.press ||
                        got.long_press !== want.long_press || got.released !== want.released ||
                        got.pressed !== want.pressed)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display("%0t: report mismatch: expected id=%0d p=%0b l=%0b r=%0b s=%0b, got id=%0d p=%0b l=%0b r=%0b s=%0b",
                                     $realtime, want.button_id, want.press, want.long_press,
                                     want.released, want.pressed, got.button_id, got.press,
                                     got.long_press, got.released, got.pressed);
                    end
                end
                if (got.press === 1'b1)      presses++;
                if (got.long_press === 1'b1) long_presses++;
                if (got.released === 1'b1)   releases++;
            end
            pending = expected_reports.size();
        end
    end

endmodule

>>> test/button_debounce_long_press_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_long_press_tb
// drives timestamped button samples and register writes into the debouncer;
// a checker beside it predicts every report item and counts failures
// ----------------------------------------------------------------------------
module button_debounce_long_press_tb
    import bdlp_pkg::*;
;

    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 147;
    localparam int HOLD_CYCLES    = 64;
    localparam int SETTLE_CYCLES  = 4;     // drains the read stage and output register, plus margin
    localparam int TIMEOUT_NS     = 5_000_000;

    // one register setting for a phase of random traffic
    typedef struct {
        logic [DEB_W-1:0]  deb;
        logic [WARM_W-1:0] warm;
        logic [LPMS_W-1:0] lpms;
        logic [MASK_W-1:0] pu;
        logic [MASK_W-1:0] lm;
        bit                rewind;   // jump back to the first timestamp, warm-up again
        bit                wrap;     // start just below the 48-bit rollover
    } setting_t;

    logic clk = 1'b0;
    logic rst_n;

    // apb side
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // checker results
    int failures;
    int pending;
    int samples;
    int presses;
    int long_presses;
    int releases;

    // idling knobs, changed per phase
    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int holdoffs_asked = 0;
    int holdoffs_done  = 0;

    bdlp_sample_if smp_ch ();
    bdlp_report_if rpt_ch ();

    button_debounce_long_press i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (smp_ch),
        .report  (rpt_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bdlp_report_checker #(
        .NUM_BUTTONS (8)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .smp          (smp_ch),
        .rpt          (rpt_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .failures     (failures),
        .pending      (pending),
        .samples      (samples),
        .presses      (presses),
        .long_presses (long_presses),
        .releases     (releases)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // hard stop in case the block hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("button_debounce_long_press_tb: done, errors");
        $finish;
    end

    // report side: random back-pressure, plus long hold-offs on request
    initial
    begin : receiver
        rpt_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holdoffs_done < holdoffs_asked)
            begin
                // keep ready low long enough for the pipeline to fill and
                // push back on the sample side
                rpt_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                holdoffs_done++;
            end
            else
            begin
                rpt_ch.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
            end
        end
    end

    // offer one sample item; called at a falling edge, returns at the falling
    // edge after acceptance with valid still high so the next item can follow
    // back to back
    task automatic send(input logic [IDX_W-1:0] b, input logic lvl,
                        input logic [TIME_W-1:0] t);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            smp_ch.valid <= 1'b0;
            @(negedge clk);
        end
        smp_ch.valid        <= 1'b1;
        smp_ch.button_index <= b;
        smp_ch.raw_level    <= lvl;
        smp_ch.now_us       <= t;
        do
            @(posedge clk);
        while (smp_ch.ready !== 1'b1);
        @(negedge clk);
    endtask

    // stop offering and wait until every report item is back
    task automatic settle();
        smp_ch.valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // setup cycle, access cycle, then idle so writes never abut
    task automatic apb_write(input reg_idx_t idx, input logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        setting_t          cfg [NUM_PHASES];
        logic              want       [8];
        logic [63:0]       hold_until [8];
        logic [63:0]       toggled_at [8];
        logic [63:0]       now_t;
        logic [63:0]       thr;
        logic [63:0]       deb64;
        logic [63:0]       tick;
        logic [63:0]       dur;
        logic [IDX_W-1:0]  b;
        logic              act;
        logic              lvl;
        int                focus_lo;
        int                mode;

        // every input known from time zero
        rst_n               = 1'b0;
        smp_ch.valid        = 1'b0;
        smp_ch.button_index = '0;
        smp_ch.raw_level    = 1'b0;
        smp_ch.now_us       = '0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        now_t               = '0;

        // register settings for the random phases; extremes in phases 1 to 3
        cfg[0] = '{20'd50,    24'd0,        16'd2,     8'($urandom), 8'hFF,        1'b0, 1'b0};
        cfg[1] = '{20'd0,     24'd1000,     16'd1,     8'h00,        8'($urandom), 1'b0, 1'b0};
        cfg[2] = '{20'hFFFFF, 24'hFFFFFF,   16'hFFFF,  8'hFF,        8'($urandom), 1'b0, 1'b0};
        cfg[3] = '{20'd3000,  24'd0,        16'd0,     8'($urandom), 8'hFF,        1'b0, 1'b0};
        cfg[4] = '{20'd200,   24'd30000,    16'd5,     8'($urandom), 8'($urandom), 1'b1, 1'b0};
        cfg[5] = '{20'd700,   24'd123456,   16'd3,     8'($urandom), 8'($urandom), 1'b0, 1'b1};
        cfg[6] = '{20'd1,     24'd0,        16'd1,     8'($urandom), 8'h00,        1'b0, 1'b0};
        cfg[7] = '{20'd20000, 24'd500000,   16'd1000,  8'hFF,        8'h0F,        1'b0, 1'b0};

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // ---- directed part, reset settings: all buttons active low, no long press
        // first sample ever at time zero opens the warm-up window
        send(3'd0, 1'b1, 48'd0);
        send(3'd0, 1'b0, 48'd10);            // goes active, not yet stable
        send(3'd7, 1'b0, 48'd20);
        send(3'd0, 1'b0, 48'd20010);         // stable exactly debounce_us, taken silently
        send(3'd7, 1'b1, 48'd30000);         // bounce back before acceptance
        send(3'd0, 1'b0, 48'd499999);        // last sample inside warm-up
        send(3'd0, 1'b0, 48'd500000);        // warm-up over, still held, nothing new
        send(3'd0, 1'b1, 48'd500001);
        send(3'd0, 1'b1, 48'd520000);        // one short of the debounce time
        send(3'd0, 1'b1, 48'd520001);        // release
        send(3'd7, 1'b0, 48'd600000);
        send(3'd7, 1'b0, 48'd620000);        // press
        send(3'd7, 1'b0, 48'd2000000);       // long hold, long press not enabled
        send(3'd7, 1'b1, 48'd2000000);       // same timestamp twice
        send(3'd7, 1'b1, 48'hFFFF_FFFF_FFFF); // top of the time range: release
        send(3'd3, 1'b0, 48'hFFFF_FFFF_FFFF);
        send(3'd3, 1'b0, 48'd19999);         // wraps around, and lands back in warm-up
        settle();

        // tap versus long press on one button, 1 ms threshold
        apb_write(REG_LONG_MASK, 32'hFF);
        apb_write(REG_LONG_MS, 32'd1);
        apb_write(REG_DEBOUNCE, 32'd5);
        send(3'd5, 1'b0, 48'd1000000000);
        send(3'd5, 1'b0, 48'd1000000005);    // accepted, press deferred
        send(3'd5, 1'b0, 48'd1000001005);    // long press fires
        send(3'd5, 1'b1, 48'd1000001006);
        send(3'd5, 1'b1, 48'd1000001011);    // release after long press is quiet
        send(3'd5, 1'b0, 48'd1000002000);
        send(3'd5, 1'b0, 48'd1000002005);
        send(3'd5, 1'b1, 48'd1000002100);
        send(3'd5, 1'b1, 48'd1000002105);    // short tap: press and release together
        now_t = 64'd1000003000;

        // ---- random phases
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle();

            // idle modes rotate: none, sender idle, receiver stall, both lightly
            mode = p % 4;
            snd_idle_pct  = (mode == 1) ? 74 : (mode == 3) ? 8 : 0;
            rcv_stall_pct = (mode == 2) ? 74 : (mode == 3) ? 8 : 0;

            apb_write(REG_DEBOUNCE,  32'(cfg[p].deb));
            apb_write(REG_WARMUP,    32'(cfg[p].warm));
            apb_write(REG_LONG_MS,   32'(cfg[p].lpms));
            apb_write(REG_PULL_UP,   32'(cfg[p].pu));
            apb_write(REG_LONG_MASK, 32'(cfg[p].lm));

            if (cfg[p].rewind)
                now_t = '0;
            if (cfg[p].wrap)
                now_t = 64'h0000_FFFF_FFFF_FFFF - 64'd20000;

            // time scale follows the sum of debounce time and long-press threshold
            thr   = (cfg[p].lpms == '0) ? 64'd2000 : 64'(cfg[p].lpms) * 64'd1000;
            deb64 = 64'(cfg[p].deb);
            tick  = (deb64 + thr) / 9 + 1;
            for (int i = 0; i < 8; i++)
            begin
                want[i]       = 1'($urandom_range(0, 1));
                hold_until[i] = now_t;
                toggled_at[i] = now_t;
            end
            focus_lo = $urandom_range(0, 5);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == 60 && (mode == 0 || mode == 3))
                    holdoffs_asked++;
                if (n == 100 && (p == 1 || p == 5))
                    settle();

                // mostly a few buttons so that each one gets through whole presses
                if ($urandom_range(0, 3) == 0)
                    b = IDX_W'($urandom_range(0, 7));
                else
                    b = IDX_W'(focus_lo + $urandom_range(0, 2));

                now_t += 64'($urandom_range(0, 32'(tick)));
                // rare step backwards in time
                if ($urandom_range(0, 149) == 0 && now_t > 4 * tick)
                    now_t -= 64'($urandom_range(0, 32'(2 * tick)));

                // intended level flips after a glitch, a short tap or a long hold
                if (now_t >= hold_until[b])
                begin
                    want[b]       = !want[b];
                    toggled_at[b] = now_t;
                    case ($urandom_range(0, 3))
                        0:       dur = 64'($urandom_range(0, 32'(deb64)));
                        1:       dur = deb64 + 64'($urandom_range(0, 32'(thr / 2)));
                        default: dur = deb64 + thr + 64'($urandom_range(0, 32'(thr)));
                    endcase
                    hold_until[b] = now_t + dur;
                end

                // contact bounce: heavy right after a flip, light otherwise
                act = want[b];
                if ($urandom_range(0, 99) < ((now_t - toggled_at[b] < deb64) ? 40 : 6))
                    act = 1'($urandom_range(0, 1));
                lvl = cfg[p].pu[b] ? !act : act;

                send(b, lvl, now_t[TIME_W-1:0]);
            end
        end

        settle();
        repeat (10) @(negedge clk);

        $display("run covered %0d samples over %0d register settings, four idle patterns and %0d receiver hold-offs",
                 samples, NUM_PHASES + 2, holdoffs_done);
        $display("reports carried %0d press, %0d long-press and %0d release events",
                 presses, long_presses, releases);
        if (failures == 0 && pending == 0)
            $display("button_debounce_long_press_tb: done, clean");
        else
            $display("button_debounce_long_press_tb: done, errors");
        $finish;
    end

endmodule
